>>> design/history_bar_graph_pixel_gen_defines.svh
// ----------------------------------------------------------------------------
// History bar graph pixel generator: assertion macros
// Shared property wrappers for the checker; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HISTORY_BAR_GRAPH_PIXEL_GEN_DEFINES_SVH
`define HISTORY_BAR_GRAPH_PIXEL_GEN_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HBG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HBG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/hbg_pkg.sv
// ----------------------------------------------------------------------------
// History bar graph pixel generator: package
// Sizes, operation codes, colors and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package hbg_pkg;

	localparam int SAMPLES = 64;
	localparam int IDX_W   = $clog2(SAMPLES);
	localparam int HALF    = SAMPLES / 2;

	typedef enum logic [1:0] {
		OP_ADD_LAT = 2'd0,
		OP_ADD_LVL = 2'd1,
		OP_QUERY   = 2'd2
	} op_t;

	localparam logic [31:0] COL_RED = 32'hff0000ff;
	localparam logic [31:0] COL_GRN = 32'h00ff00ff;
	localparam logic [31:0] COL_BLU = 32'h0000ffff;
	localparam logic [31:0] COL_YLW = 32'hffff00ff;
	localparam logic [31:0] COL_BG1 = 32'h111111ff;
	localparam logic [31:0] COL_BG2 = 32'h222222ff;

	typedef struct packed {
		logic wr_lat;
		logic wr_lvl;
		logic rd;
		logic eval;
	} cmd_t;

endpackage

`default_nettype wire

>>> design/hbg_ctrl.sv
// ----------------------------------------------------------------------------
// History bar graph pixel generator: controller
// Decodes accepted requests into datapath commands and sequences pixel queries.
// ----------------------------------------------------------------------------
`default_nettype none

module hbg_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  op,
	output logic             busy,
	output hbg_pkg::cmd_t    cmd
);
	import hbg_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_comb begin
		cmd        = '0;
		cmd.eval   = (state_q == ST_EVAL);
		if (accept) begin
			case (op)
				OP_ADD_LAT: cmd.wr_lat = 1'b1;
				OP_ADD_LVL: cmd.wr_lvl = 1'b1;
				OP_QUERY:   cmd.rd     = 1'b1;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_QUERY) begin
						state_q <= ST_EVAL;
						busy_q  <= 1'b1;
					end
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/hbg_dp.sv
// ----------------------------------------------------------------------------
// History bar graph pixel generator: datapath
// Holds both sample rings and heads, reads one entry of each per query and colors it.
// ----------------------------------------------------------------------------
`default_nettype none

module hbg_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hbg_pkg::cmd_t      cmd,
	input  wire logic signed [15:0] snapshot_ms,
	input  wire logic [15:0]        interp_level,
	input  wire logic [5:0]         pixel_row,
	input  wire logic [5:0]         pixel_column,
	output logic [31:0]             pixel_rgba,
	output logic                    done
);
	import hbg_pkg::*;

	logic [15:0]        lat_mem [SAMPLES];
	logic [15:0]        lvl_mem [SAMPLES];
	logic [SAMPLES-1:0] lat_vld_q;
	logic [SAMPLES-1:0] lvl_vld_q;
	logic [IDX_W-1:0]   lat_head_q;
	logic [IDX_W-1:0]   lvl_head_q;
	logic [IDX_W-1:0]   lat_wa;
	logic [IDX_W-1:0]   lvl_wa;
	logic [IDX_W-1:0]   lat_ra;
	logic [IDX_W-1:0]   lvl_ra;
	logic [IDX_W-1:0]   row;
	logic [IDX_W-1:0]   col;

	logic [15:0]        lat_rd_s1;
	logic [15:0]        lvl_rd_s1;
	logic               lat_vld_s1;
	logic               lvl_vld_s1;
	logic [IDX_W-1:0]   row_s1;
	logic [IDX_W-1:0]   col_s1;

	logic [15:0]        lat_val;
	logic [15:0]        lvl_val;
	logic [17:0]        lvl_x4;
	logic [17:0]        lvl_need;
	logic [13:0]        lat_bar;
	logic [13:0]        lat_need;
	logic [IDX_W-1:0]   shade_x;
	logic [IDX_W-1:0]   shade_head;
	logic [31:0]        shade_col;
	logic [31:0]        pixel_d;

	logic [31:0]        pixel_q;
	logic               done_q;

	assign row    = pixel_row[IDX_W-1:0];
	assign col    = pixel_column[IDX_W-1:0];
	assign lat_wa = lat_head_q + IDX_W'(1);
	assign lvl_wa = lvl_head_q + IDX_W'(1);
	assign lat_ra = lat_wa + col;
	assign lvl_ra = lvl_wa + col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_head_q <= '0;
			lvl_head_q <= '0;
			lat_vld_q  <= '0;
			lvl_vld_q  <= '0;
		end else begin
			if (cmd.wr_lat) begin
				lat_head_q         <= lat_wa;
				lat_vld_q[lat_wa]  <= 1'b1;
			end
			if (cmd.wr_lvl) begin
				lvl_head_q         <= lvl_wa;
				lvl_vld_q[lvl_wa]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_lat) begin
			lat_mem[lat_wa] <= snapshot_ms;
		end
		if (cmd.rd) begin
			lat_rd_s1 <= lat_mem[lat_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_lvl) begin
			lvl_mem[lvl_wa] <= interp_level;
		end
		if (cmd.rd) begin
			lvl_rd_s1 <= lvl_mem[lvl_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			lat_vld_s1 <= lat_vld_q[lat_ra];
			lvl_vld_s1 <= lvl_vld_q[lvl_ra];
			row_s1     <= row;
			col_s1     <= col;
		end
	end

	assign lat_val  = lat_vld_s1 ? lat_rd_s1 : 16'd0;
	assign lvl_val  = lvl_vld_s1 ? lvl_rd_s1 : 16'd0;
	assign lvl_x4   = {lvl_val, 2'b00};
	assign lvl_need = 18'((HALF - int'(row_s1)) * 256);
	assign lat_bar  = 14'(lat_val[15:3]) + 14'd1;
	assign lat_need = 14'(2 * HALF - int'(row_s1));

	assign shade_head = (int'(row_s1) < HALF) ? lvl_head_q : lat_head_q;
	assign shade_x    = shade_head + col_s1;
	assign shade_col  = (int'(shade_x) >= HALF) ? COL_BG1 : COL_BG2;

	always_comb begin
		if (int'(row_s1) < HALF) begin
			if (lvl_x4 >= lvl_need) begin
				pixel_d = (lvl_val <= 16'd256) ? COL_BLU : COL_YLW;
			end else begin
				pixel_d = shade_col;
			end
		end else if (lat_val[15]) begin
			pixel_d = COL_RED;
		end else if (lat_bar >= lat_need) begin
			pixel_d = COL_GRN;
		end else begin
			pixel_d = shade_col;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			pixel_q <= pixel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.eval;
		end
	end

	assign pixel_rgba = pixel_q;
	assign done       = done_q;

endmodule

`default_nettype wire

>>> design/history_bar_graph_pixel_gen.sv
// ----------------------------------------------------------------------------
// History bar graph pixel generator: top level
// Two 64-entry sample rings drawn as a bar graph, one pixel per query request.
// ----------------------------------------------------------------------------
// Requests are taken at a rising edge where start is high and busy is low;
// op selects add latency sample, add level sample or query pixel.
// An add leaves busy low, so a request may follow at once.
// A query reads both rings at the addressed column in the accept cycle,
// colors the pixel in the next cycle with busy high, and presents it on
// pixel_rgba with done high for exactly one cycle after that. The registered
// ring read is followed by the color stage, and no request is accepted while
// busy is high.
// A new request may be accepted in the same cycle that done is high.
// The receiver cannot stall; done is high for one cycle only, and pixel_rgba
// holds the pixel until the next query. Reset clears both heads and the
// per-entry valid bits, so every ring entry reads as zero until written; no
// clearing pass is needed.
`default_nettype none

module history_bar_graph_pixel_gen (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         op,
	input  wire logic signed [15:0] snapshot_ms,
	input  wire logic [15:0]        interp_level,
	input  wire logic [5:0]         pixel_row,
	input  wire logic [5:0]         pixel_column,
	output logic                    done,
	output logic [31:0]             pixel_rgba
);
	import hbg_pkg::*;

	cmd_t cmd;

	hbg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.cmd    (cmd)
	);

	hbg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.snapshot_ms  (snapshot_ms),
		.interp_level (interp_level),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.pixel_rgba   (pixel_rgba),
		.done         (done)
	);

endmodule

`default_nettype wire

>>> design/hbg_chk.sv
// ----------------------------------------------------------------------------
// History bar graph pixel generator: port checker
// Checks request sequencing and result strobe timing seen at the top ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "history_bar_graph_pixel_gen_defines.svh"

module hbg_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [1:0]         op,
	input wire logic               done
);
	import hbg_pkg::*;

	`HBG_ASSERT_NEXT(a_query_busy, start && !busy && op == OP_QUERY, busy, "Query request did not raise busy.")
	`HBG_ASSERT_NEXT(a_add_quiet, start && !busy && op != OP_QUERY, !busy && !done, "Non-query request produced busy or a result.")
	`HBG_ASSERT_NEXT(a_busy_done, busy, !busy && done, "Busy cycle was not followed by a result.")
	`HBG_ASSERT_SAME(a_done_cause, done, $past(busy), "Result strobe without a preceding busy cycle.")

endmodule

bind history_bar_graph_pixel_gen hbg_chk u_hbg_chk (.*);

`default_nettype wire
